// File: hdl/rbsa_pkg.sv
`timescale 1ns / 1ps
// rbsa_pkg: widths, codes, state types and control structs of the buffer slot allocator.
// Used by every module of the block but rbsa_ram; depends on nothing.
package rbsa_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 48;
  localparam int BPC_W      = 7;
  localparam int CIU_W      = 5;
  localparam int CID_IN_W   = 4;
  localparam int SLOT_OUT_W = 6;
  localparam int CNT_OUT_W  = 7;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Slot address accumulator: wide enough for base plus full client and slot offsets
  localparam int ACC_W = 50;

  // Parameter defaults
  localparam int MAX_CLIENTS_DEF = 16;
  localparam int MAX_SLOTS_DEF   = 64;
  localparam int BUF_BYTES_DEF   = 4096;

  // Register reset values
  localparam logic [BPC_W-1:0] BPC_RST = 7'd64;
  localparam logic [CIU_W-1:0] CIU_RST = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_SLOT   = 2'd2,
    ST_BAD_CLIENT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE     = 2'd0,
    CFG_BUFS_PER_CLIENT = 2'd1,
    CFG_CLIENTS_IN_USE  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_BASE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    ADD_ZERO,
    ADD_BASE,
    ADD_BUF
  } add_sel_e;

  // Sequencer to scan unit
  typedef struct packed {
    logic     load_prod;
    logic     load_row;
    logic     add_en;
    add_sel_e add_sel;
    logic     step;
  } scan_ctrl_t;

  // Scan unit to sequencer
  typedef struct packed {
    logic lt;
    logic bit0;
  } scan_stat_t;

  // Sequencer to top level: request finished
  typedef struct packed {
    logic    fire;
    logic    commit;
    status_e status;
  } seq_res_t;

endpackage

// File: hdl/rbsa_ram.sv
`timescale 1ns / 1ps
// rbsa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rbsa_scan_unit.sv
`timescale 1ns / 1ps
// rbsa_scan_unit: shared address adder and compare, slot shift register and slot counter.
// Depends on rbsa_pkg.
module rbsa_scan_unit #(
  parameter int MAX_SLOTS = rbsa_pkg::MAX_SLOTS_DEF,
  parameter int BUF_BYTES = rbsa_pkg::BUF_BYTES_DEF,
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                          clk_i,
  input  rbsa_pkg::scan_ctrl_t          ctrl_i,
  input  logic [rbsa_pkg::CID_IN_W-1:0] client_i,
  input  logic [rbsa_pkg::ADDR_W-1:0]   region_base_i,
  input  logic [rbsa_pkg::ADDR_W-1:0]   faddr_i,
  input  logic [MAX_SLOTS-1:0]          row_i,
  output rbsa_pkg::scan_stat_t          stat_o,
  output logic [rbsa_pkg::ACC_W-1:0]    acc_o,
  output logic [SLOT_W-1:0]             slot_o,
  output logic [MAX_SLOTS-1:0]          row_wb_o
);
  import rbsa_pkg::*;

  localparam logic [ACC_W-1:0] STRIDE   = ACC_W'(longint'(MAX_SLOTS) * longint'(BUF_BYTES));
  localparam logic [ACC_W-1:0] BUF_STEP = ACC_W'(BUF_BYTES);

  logic [ACC_W-1:0]     acc_q;
  logic [ACC_W-1:0]     addend;
  logic [ACC_W-1:0]     sum;
  logic [MAX_SLOTS-1:0] row_q;
  logic [MAX_SLOTS-1:0] orig_q;
  logic [SLOT_W-1:0]    slot_q;

  // Pick the addend of the shared adder
  always_comb begin
    case (ctrl_i.add_sel)
      ADD_BASE: addend = ACC_W'(region_base_i);
      ADD_BUF:  addend = BUF_STEP;
      default:  addend = '0;
    endcase
  end

  // Shared adder and compare against the request address
  assign sum         = acc_q + addend;
  assign stat_o.lt   = ACC_W'(faddr_i) < sum;
  assign stat_o.bit0 = row_q[0];

  // Advance accumulator, in-use row and slot counter
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_prod) begin
      acc_q <= ACC_W'(client_i) * STRIDE;
    end else if (ctrl_i.add_en) begin
      acc_q <= sum;
    end
    if (ctrl_i.load_row) begin
      row_q  <= row_i;
      orig_q <= row_i;
      slot_q <= '0;
    end else if (ctrl_i.step) begin
      row_q  <= row_q >> 1;
      slot_q <= slot_q + SLOT_W'(1);
    end
  end

  // Flip the chosen slot's flag for write-back
  assign row_wb_o = orig_q ^ (MAX_SLOTS'(1) << slot_q);
  assign acc_o    = acc_q;
  assign slot_o   = slot_q;

endmodule

// File: hdl/rbsa_seq.sv
`timescale 1ns / 1ps
// rbsa_seq: request sequencer; checks the client, drives the scan unit, picks the status.
// Depends on rbsa_pkg.
module rbsa_seq #(
  parameter int MAX_CLIENTS = rbsa_pkg::MAX_CLIENTS_DEF,
  parameter int MAX_SLOTS   = rbsa_pkg::MAX_SLOTS_DEF,
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int NB_W   = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  logic                          mode_i,
  input  logic [rbsa_pkg::CID_IN_W-1:0] client_i,
  input  logic [rbsa_pkg::CIU_W-1:0]    ciu_i,
  input  logic [rbsa_pkg::BPC_W-1:0]    bufs_i,
  input  logic [NB_W-1:0]               cnt_i,
  input  logic [SLOT_W-1:0]             slot_i,
  input  rbsa_pkg::scan_stat_t          stat_i,
  input  logic                          out_free_i,
  output logic                          busy_o,
  output rbsa_pkg::scan_ctrl_t          ctrl_o,
  output rbsa_pkg::seq_res_t            res_o
);
  import rbsa_pkg::*;

  localparam int CMP_W = (NB_W > BPC_W) ? NB_W : BPC_W;

  seq_state_e        state_q, state_d;
  status_e           st_q, st_d;
  logic              client_ok;
  logic [CMP_W-1:0]  bufs_ext;
  logic [NB_W-1:0]   nb;
  logic              pool_full;
  logic              alloc_last;
  logic              free_last;

  // Client and pool limits
  assign client_ok  = ({1'b0, client_i} < ciu_i) && (32'(client_i) < 32'(MAX_CLIENTS));
  assign bufs_ext   = CMP_W'(bufs_i);
  assign nb         = (bufs_ext > CMP_W'(MAX_SLOTS)) ? NB_W'(MAX_SLOTS) : NB_W'(bufs_ext);
  assign pool_full  = cnt_i >= nb;
  assign alloc_last = (NB_W'(slot_i) + NB_W'(1)) == nb;
  assign free_last  = slot_i == SLOT_W'(MAX_SLOTS - 1);

  // State and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // Next state and scan control
  always_comb begin
    state_d        = state_q;
    st_d           = st_q;
    ctrl_o         = '0;
    ctrl_o.add_sel = ADD_ZERO;
    res_o          = '0;
    res_o.status   = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (!client_ok) begin
          st_d    = ST_BAD_CLIENT;
          state_d = S_DONE;
        end else begin
          ctrl_o.load_prod = 1'b1;
          state_d          = S_BASE;
        end
      end
      S_BASE: begin
        ctrl_o.load_row = 1'b1;
        ctrl_o.add_en   = 1'b1;
        ctrl_o.add_sel  = ADD_BASE;
        if (mode_i == MODE_FREE) begin
          state_d = S_CHECK;
        end else if (pool_full) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_CHECK: begin
        // drop addresses below the client's region
        ctrl_o.add_sel = ADD_ZERO;
        if (stat_i.lt) begin
          st_d    = ST_BAD_SLOT;
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl_o.add_sel = ADD_BUF;
        if (mode_i == MODE_ALLOC) begin
          if (!stat_i.bit0) begin
            st_d    = ST_OK;
            state_d = S_DONE;
          end else if (alloc_last) begin
            st_d    = ST_FULL;
            state_d = S_DONE;
          end else begin
            ctrl_o.add_en = 1'b1;
            ctrl_o.step   = 1'b1;
          end
        end else begin
          // address falls before the next slot's start: this slot holds it
          if (stat_i.lt) begin
            st_d    = (stat_i.bit0 && (cnt_i != '0)) ? ST_OK : ST_BAD_SLOT;
            state_d = S_DONE;
          end else if (free_last) begin
            st_d    = ST_BAD_SLOT;
            state_d = S_DONE;
          end else begin
            ctrl_o.add_en = 1'b1;
            ctrl_o.step   = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_o.fire   = 1'b1;
          res_o.commit = (st_q == ST_OK);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: hdl/rdma_buffer_slot_allocator.sv
`timescale 1ns / 1ps
// rdma_buffer_slot_allocator: top level; config registers, per-client counts, slot RAM,
// output register. Depends on rbsa_pkg, rbsa_ram, rbsa_scan_unit and rbsa_seq.

// Per-client first-fit buffer slot allocator. Each request allocates the lowest free
// slot of a client or frees the slot holding an address, and yields one result. The
// block takes one request at a time and stalls its input meanwhile. An allocate on a
// full pool ends before the slot scan, a free of an address below the client's region
// ends at the region check, and a bad client ends at the client check. In the slot scan,
// one shared adder and compare steps through the client's in-use row one slot a cycle.
// In-use flags live in a RAM of one row per client; per-row valid flops clear at reset,
// so there is no clearing pass. A finished result waits in an output register.
module rdma_buffer_slot_allocator #(
  parameter int MAX_CLIENTS = rbsa_pkg::MAX_CLIENTS_DEF,
  parameter int MAX_SLOTS   = rbsa_pkg::MAX_SLOTS_DEF,
  parameter int BUF_BYTES   = rbsa_pkg::BUF_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [rbsa_pkg::CID_IN_W-1:0]   client_id_i,
  input  logic [rbsa_pkg::ADDR_W-1:0]     free_address_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rbsa_pkg::STATUS_W-1:0]   status_o,
  output logic [rbsa_pkg::ADDR_W-1:0]     buffer_address_o,
  output logic [rbsa_pkg::SLOT_OUT_W-1:0] slot_index_o,
  output logic [rbsa_pkg::CNT_OUT_W-1:0]  used_count_o
);
  import rbsa_pkg::*;

  localparam int CID_W  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  logic [ADDR_W-1:0]     region_base_q;
  logic [BPC_W-1:0]      bufs_q;
  logic [CIU_W-1:0]      ciu_q;
  logic                  mode_q;
  logic [CID_IN_W-1:0]   client_q;
  logic [ADDR_W-1:0]     faddr_q;
  logic [CID_W-1:0]      cli_idx;
  logic [CNT_W-1:0]      cnt_q [MAX_CLIENTS];
  logic [CNT_W-1:0]      cnt_cur;
  logic [CNT_W-1:0]      cnt_new;
  logic [MAX_CLIENTS-1:0] row_valid_q;
  logic [MAX_SLOTS-1:0]  ram_rdata;
  logic [MAX_SLOTS-1:0]  row_in;
  logic [MAX_SLOTS-1:0]  row_wb;
  logic [ACC_W-1:0]      acc;
  logic [SLOT_W-1:0]     slot;
  logic                  in_fire;
  logic                  busy;
  logic                  out_free;
  scan_ctrl_t            ctrl;
  scan_stat_t            stat;
  seq_res_t              res;
  logic                  out_valid_q;
  status_e               status_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [CNT_OUT_W-1:0]  used_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
      bufs_q        <= BPC_RST;
      ciu_q         <= CIU_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REGION_BASE:     region_base_q <= cfg_data_i[ADDR_W-1:0];
        CFG_BUFS_PER_CLIENT: bufs_q        <= cfg_data_i[BPC_W-1:0];
        CFG_CLIENTS_IN_USE:  ciu_q         <= cfg_data_i[CIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  assign in_fire    = in_valid_i && !busy;
  assign in_stall_o = busy;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= mode_i;
      client_q <= client_id_i;
      faddr_q  <= free_address_i;
    end
  end

  assign cli_idx = CID_W'(client_q);
  assign cnt_cur = cnt_q[cli_idx];
  assign cnt_new = (mode_q == MODE_ALLOC) ? (cnt_cur + CNT_W'(1)) : (cnt_cur - CNT_W'(1));

  // Per-client counts and row valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '{default: '0};
      row_valid_q <= '0;
    end else if (res.commit) begin
      cnt_q[cli_idx]       <= cnt_new;
      row_valid_q[cli_idx] <= 1'b1;
    end
  end

  // In-use flags, one row per client
  rbsa_ram #(
    .WIDTH (MAX_SLOTS),
    .DEPTH (MAX_CLIENTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (res.commit),
    .waddr_i (cli_idx),
    .wdata_i (row_wb),
    .raddr_i (cli_idx),
    .rdata_o (ram_rdata)
  );

  // A row never written reads as all free
  assign row_in = row_valid_q[cli_idx] ? ram_rdata : '0;

  rbsa_scan_unit #(
    .MAX_SLOTS (MAX_SLOTS),
    .BUF_BYTES (BUF_BYTES)
  ) u_scan (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .client_i      (client_q),
    .region_base_i (region_base_q),
    .faddr_i       (faddr_q),
    .row_i         (row_in),
    .stat_o        (stat),
    .acc_o         (acc),
    .slot_o        (slot),
    .row_wb_o      (row_wb)
  );

  rbsa_seq #(
    .MAX_CLIENTS (MAX_CLIENTS),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .mode_i     (mode_q),
    .client_i   (client_q),
    .ciu_i      (ciu_q),
    .bufs_i     (bufs_q),
    .cnt_i      (cnt_cur),
    .slot_i     (slot),
    .stat_i     (stat),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl),
    .res_o      (res)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.fire) begin
      status_q <= res.status;
      addr_q   <= (res.status == ST_OK) ? acc[ADDR_W-1:0] : '0;
      slot_q   <= (res.status == ST_OK) ? SLOT_OUT_W'(slot) : '0;
      if (res.status == ST_BAD_CLIENT) begin
        used_q <= '0;
      end else begin
        used_q <= CNT_OUT_W'(res.commit ? cnt_new : cnt_cur);
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign buffer_address_o = addr_q;
  assign slot_index_o     = slot_q;
  assign used_count_o     = used_q;

endmodule

// File: hdl/rbsa_chk.sv
`timescale 1ns / 1ps
// rbsa_chk: port-level checks of the buffer slot allocator, bound to the top level.
// Depends on rbsa_pkg.
module rbsa_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [rbsa_pkg::STATUS_W-1:0]   status_o,
  input logic [rbsa_pkg::ADDR_W-1:0]     buffer_address_o,
  input logic [rbsa_pkg::SLOT_OUT_W-1:0] slot_index_o,
  input logic [rbsa_pkg::CNT_OUT_W-1:0]  used_count_o
);
  import rbsa_pkg::*;

  // Block turns busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after request accepted");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(buffer_address_o) && $stable(slot_index_o) && $stable(used_count_o))
    else $error("stalled result changed");

  // Errors report no buffer
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (buffer_address_o == '0) && (slot_index_o == '0))
    else $error("error result carries an address or slot");

  // Bad client reports no count
  a_bad_client_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BAD_CLIENT) |-> (used_count_o == '0))
    else $error("bad client result carries a count");

endmodule

bind rdma_buffer_slot_allocator rbsa_chk u_rbsa_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .buffer_address_o (buffer_address_o),
  .slot_index_o     (slot_index_o),
  .used_count_o     (used_count_o)
);

// File: bench/rdma_buffer_slot_allocator_tb.sv
`timescale 1ns / 1ps
// rdma_buffer_slot_allocator_tb: self-checking bench for the per-client slot allocator.
// Drives allocate and free requests, tracks slot state in its own model and checks each
// result. Depends on rbsa_pkg and rdma_buffer_slot_allocator.
module rdma_buffer_slot_allocator_tb;
  import rbsa_pkg::*;

  localparam int NUM_CLIENTS   = MAX_CLIENTS_DEF;
  localparam int NUM_SLOTS     = MAX_SLOTS_DEF;
  localparam int SLOT_BYTES    = BUF_BYTES_DEF;
  localparam int REGION_STRIDE = NUM_SLOTS * SLOT_BYTES;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_PRINTS    = 100;

  typedef struct {
    mode_e                mode;
    logic [CID_IN_W-1:0]  cid;
    logic [ADDR_W-1:0]    addr;
  } slot_req_t;

  typedef struct {
    status_e                status;
    logic [ADDR_W-1:0]      addr;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [CNT_OUT_W-1:0]   count;
  } slot_result_t;

  // Block ports
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i         = 1'b0;
  logic [CID_IN_W-1:0]   client_id_i    = '0;
  logic [ADDR_W-1:0]     free_address_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [ADDR_W-1:0]     buffer_address_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;
  logic [CNT_OUT_W-1:0]  used_count_o;

  // Allocator model: register copies and slot state
  logic [ADDR_W-1:0]    region_base  = '0;
  logic [BPC_W-1:0]     pool_size    = BPC_RST;
  logic [CIU_W-1:0]     live_clients = CIU_RST;
  bit                   in_use   [NUM_CLIENTS][NUM_SLOTS];
  logic [CNT_OUT_W-1:0] used_cnt [NUM_CLIENTS];

  // Request and result bookkeeping
  slot_req_t    slot_requests[$];
  slot_result_t slot_results_due[$];
  int           queued_cnt   = 0;
  int           offered_cnt  = 0;
  int           accepted_cnt = 0;
  int           gap_left     = 0;
  int           stall_left   = 0;
  int           hold_asked   = 0;
  int           hold_given   = 0;
  int           mismatches   = 0;
  bit           no_idle      = 1'b0;

  rdma_buffer_slot_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .client_id_i     (client_id_i),
    .free_address_i  (free_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .buffer_address_o(buffer_address_o),
    .slot_index_o    (slot_index_o),
    .used_count_o    (used_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out one request's result and update the slot state
  function automatic slot_result_t predict_slot(mode_e mode, logic [CID_IN_W-1:0] cid,
                                                logic [ADDR_W-1:0] faddr);
    slot_result_t res;
    logic [63:0]  cbase;
    logic [63:0]  idx;
    int           usable;
    int           pick;
    int           i;
    res = '{ST_BAD_CLIENT, '0, '0, '0};
    usable = (pool_size > NUM_SLOTS) ? NUM_SLOTS : int'(pool_size);
    if (cid >= live_clients || cid >= NUM_CLIENTS) return res;
    cbase = 64'(region_base) + 64'(cid) * REGION_STRIDE;
    res.count = used_cnt[cid];
    if (mode == MODE_ALLOC) begin
      pick = -1;
      if (used_cnt[cid] < usable) begin
        for (i = 0; i < usable; i++) begin
          if (!in_use[cid][i]) begin
            pick = i;
            break;
          end
        end
      end
      if (pick < 0) begin
        res.status = ST_FULL;
      end else begin
        in_use[cid][pick] = 1'b1;
        used_cnt[cid]++;
        res = '{ST_OK, ADDR_W'(cbase + 64'(pick) * SLOT_BYTES), SLOT_OUT_W'(pick),
                used_cnt[cid]};
      end
    end else begin
      res.status = ST_BAD_SLOT;
      if (64'(faddr) >= cbase) begin
        idx = (64'(faddr) - cbase) / SLOT_BYTES;
        if (idx < NUM_SLOTS && in_use[cid][idx[5:0]] && used_cnt[cid] != 0) begin
          in_use[cid][idx[5:0]] = 1'b0;
          used_cnt[cid]--;
          res = '{ST_OK, ADDR_W'(cbase + idx * SLOT_BYTES), idx[SLOT_OUT_W-1:0],
                  used_cnt[cid]};
        end
      end
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 80);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send(mode_e mode, logic [CID_IN_W-1:0] cid, logic [ADDR_W-1:0] addr);
    slot_requests.push_back('{mode, cid, addr});
    queued_cnt++;
  endtask

  // Register write; the model copy follows at once since the block is idle
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_REGION_BASE:     region_base = data[ADDR_W-1:0];
      CFG_BUFS_PER_CLIENT: pool_size = data[BPC_W-1:0];
      default:             live_clients = data[CIU_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued request is accepted and answered
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || slot_results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Queue a mix of allocates, well-formed frees and noise
  task automatic queue_random(int count, int alloc_pct);
    int                  n;
    int                  lim;
    int                  usable;
    int                  slot;
    logic [CID_IN_W-1:0] cid;
    logic [63:0]         a;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 12) begin
        send(mode_e'($urandom_range(0, 1)), CID_IN_W'($urandom_range(0, 15)), rand_addr());
      end else begin
        lim = (live_clients > NUM_CLIENTS) ? NUM_CLIENTS : int'(live_clients);
        if (lim == 0 || $urandom_range(0, 9) == 0) cid = CID_IN_W'($urandom_range(0, 15));
        else cid = CID_IN_W'($urandom_range(0, lim - 1));
        if ($urandom_range(0, 99) < alloc_pct) begin
          send(MODE_ALLOC, cid, rand_addr());
        end else begin
          // Favor low slots, where first fit puts the buffers
          usable = (pool_size > NUM_SLOTS) ? NUM_SLOTS : int'(pool_size);
          if (usable == 0 || $urandom_range(0, 19) == 0)
            slot = $urandom_range(usable, NUM_SLOTS + 1);
          else
            slot = $urandom_range(0, $urandom_range(0, usable - 1));
          a = 64'(region_base) + 64'(cid) * REGION_STRIDE + 64'(slot) * SLOT_BYTES +
              64'($urandom_range(0, SLOT_BYTES - 1));
          send(MODE_FREE, cid, a[ADDR_W-1:0]);
        end
      end
    end
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] base, logic [BPC_W-1:0] bpc,
                           logic [CIU_W-1:0] ciu, bit junk, bit hold, int count,
                           int alloc_pct);
    logic [CFG_DATA_W-1:0] hi;
    hi = junk ? rand_addr() : '0;
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_BUFS_PER_CLIENT, {hi[CFG_DATA_W-1:BPC_W], bpc});
    write_reg(CFG_CLIENTS_IN_USE, {hi[CFG_DATA_W-1:CIU_W], ciu});
    if (hold) hold_asked++;
    queue_random(count, alloc_pct);
    wait_idle();
  endtask

  // Driver: present queued requests, hold each until accepted
  always @(negedge clk_i) begin
    bit        launch;
    slot_req_t nxt;
    if (rst_ni) begin
      launch = 1'b0;
      if (in_valid_i) begin
        if (accepted_cnt == offered_cnt) begin
          gap_left = pick_gap();
          launch = (gap_left == 0 && slot_requests.size() > 0);
        end
      end else begin
        if (gap_left > 0) gap_left--;
        launch = (gap_left == 0 && slot_requests.size() > 0);
      end
      if (launch) begin
        nxt = slot_requests.pop_front();
        mode_i         <= nxt.mode;
        client_id_i    <= nxt.cid;
        free_address_i <= nxt.addr;
        in_valid_i     <= 1'b1;
        offered_cnt++;
      end else if (in_valid_i && accepted_cnt == offered_cnt) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Record the expected result of each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      slot_results_due.push_back(predict_slot(mode_e'(mode_i), client_id_i, free_address_i));
      accepted_cnt++;
    end
  end

  // Result stall: random short and long holds, plus requested long hold-offs
  always @(negedge clk_i) begin
    int r;
    if (rst_ni) begin
      if (hold_given < hold_asked) begin
        hold_given++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(20, 60);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (slot_results_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = slot_results_due.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %s", status_o, want.status.name()));
        if (buffer_address_o !== want.addr)
          report_mismatch($sformatf("buffer_address %h, want %h", buffer_address_o,
                                    want.addr));
        if (slot_index_o !== want.slot)
          report_mismatch($sformatf("slot_index %0d, want %0d", slot_index_o, want.slot));
        if (used_count_o !== want.count)
          report_mismatch($sformatf("used_count %0d, want %0d", used_count_o, want.count));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int k;
    foreach (used_cnt[c]) used_cnt[c] = '0;
    foreach (in_use[c, s]) in_use[c][s] = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: alloc, unaligned free, double free, below region, past pool
    send(MODE_ALLOC, 4'd0, '0);
    send(MODE_ALLOC, 4'd15, '1);
    send(MODE_FREE, 4'd0, 48'h0000_0000_0FFF);
    send(MODE_FREE, 4'd0, '0);
    send(MODE_FREE, 4'd1, '0);
    send(MODE_FREE, 4'd0, 48'(REGION_STRIDE));
    send(MODE_FREE, 4'd15, '1);
    send(MODE_FREE, 4'd15, 48'(15 * REGION_STRIDE));
    wait_idle();

    // No client accepted, then two clients
    write_reg(CFG_CLIENTS_IN_USE, '0);
    send(MODE_ALLOC, 4'd0, '0);
    wait_idle();
    write_reg(CFG_CLIENTS_IN_USE, 48'd2);
    send(MODE_ALLOC, 4'd2, '0);
    send(MODE_ALLOC, 4'd1, '0);
    wait_idle();

    // Zero slot count, pool full, then drain a slot above a lowered count
    write_reg(CFG_BUFS_PER_CLIENT, '0);
    send(MODE_ALLOC, 4'd0, '0);
    wait_idle();
    write_reg(CFG_BUFS_PER_CLIENT, 48'd2);
    send(MODE_ALLOC, 4'd1, '0);
    send(MODE_ALLOC, 4'd1, '0);
    wait_idle();
    write_reg(CFG_BUFS_PER_CLIENT, 48'd1);
    send(MODE_FREE, 4'd1, 48'(REGION_STRIDE + SLOT_BYTES + 5));
    send(MODE_ALLOC, 4'd1, '0);
    send(MODE_FREE, 4'd1, 48'(REGION_STRIDE + 7));
    wait_idle();

    // Region at the top of the address space: wrapped addresses
    write_reg(CFG_REGION_BASE, 48'hFFFF_FFFF_F000);
    write_reg(CFG_BUFS_PER_CLIENT, 48'd2);
    send(MODE_ALLOC, 4'd0, '0);
    send(MODE_ALLOC, 4'd0, '0);
    send(MODE_FREE, 4'd0, '1);
    send(MODE_FREE, 4'd1, 48'h10);
    wait_idle();

    // Random phases over several settings
    run_phase('0, 7'd64, 5'd16, 1'b0, 1'b0, 100, 50);
    run_phase(rand_addr(), 7'd4, 5'd3, 1'b1, 1'b1, 120, 50);
    run_phase(rand_addr(), 7'd127, 5'd1, 1'b0, 1'b0, 130, 85);
    run_phase(48'hFFFF_FFF0_0000, 7'd8, 5'd31, 1'b1, 1'b0, 100, 50);
    no_idle = 1'b1;
    run_phase(rand_addr(), 7'd1, 5'd16, 1'b0, 1'b0, 100, 50);
    no_idle = 1'b0;
    for (k = 0; k < 5; k++) begin
      run_phase((k == 0) ? '1 : rand_addr(), BPC_W'($urandom_range(0, 127)),
                CIU_W'($urandom_range(0, 31)), bit'($urandom_range(0, 1)),
                (k == 2), 50, $urandom_range(35, 65));
    end

    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && slot_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rbsa_pkg.sv
hdl/rbsa_ram.sv
hdl/rbsa_scan_unit.sv
hdl/rbsa_seq.sv
hdl/rdma_buffer_slot_allocator.sv
hdl/rbsa_chk.sv
bench/rdma_buffer_slot_allocator_tb.sv
